FILE: hw/rtl/rars_pkg.sv
// shared constants and types for the range add / range sum store
// no dependencies
`default_nettype none
package rars_pkg;
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int SUM_W = 48;
	localparam int SIZE_W = 11;
	localparam int CFG_USED_SIZE = 0;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PRD, S_PAC, S_PMUL, S_PSUB, S_OUT, S_UMUL, S_URD, S_UWR
	} state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/range_add_range_sum_tree.sv
// range add / range sum store over two binary indexed trees in block memory
// uses rars_pkg
// a query walks down the tree from each of its two prefix indices, one read per set bit,
// then multiplies and subtracts before the result beat; an empty range goes straight to it
// an update then walks up both trees, reading and writing each node, at lo and past the clipped hi
// one beat at a time, next beat taken only while busy is low; reset: clearing pass
// over every tree address with busy high; results cannot be stalled
`default_nettype none
module range_add_range_sum_tree #(
	parameter int MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [9:0]  lo,
	input  wire logic [9:0]  hi,
	input  wire logic signed [31:0] add_value,
	output logic             range_valid,
	output logic signed [47:0] range_sum,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int PW = AW + 2;
	localparam int DW = rars_pkg::SUM_W;
	localparam int SW = rars_pkg::SIZE_W;
	localparam logic [PW-1:0] NMAX = PW'(MAX_ELEMENTS);
	localparam logic [SW-1:0] SIZE_RST = (MAX_ELEMENTS > 2047) ? {SW{1'b1}} : SW'(MAX_ELEMENTS);

	rars_pkg::state_t state_q, state_d;

	logic [SW-1:0] used_q;
	logic [AW-1:0] clr_q;
	logic [PW-1:0] pos_q, idx_q, lo_q, hic_q;
	logic [DW-1:0] s1_q, s2_q, prod_q, total_q, d1_q, d2_q, b1_rd_q, b2_rd_q;
	logic          op_q, second_q, uphase_q;
	logic signed [31:0] v_q;

	// tree memories
	logic [DW-1:0] b1_mem [MAX_ELEMENTS];
	logic [DW-1:0] b2_mem [MAX_ELEMENTS];
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [DW-1:0] wd1, wd2;

	always_ff @(posedge clk) begin
		if (we) begin
			b1_mem[wa] <= wd1;
			b2_mem[wa] <= wd2;
		end
		b1_rd_q <= b1_mem[ra];
		b2_rd_q <= b2_mem[ra];
	end

	// config port
	assign pready = 1'b1;
	assign prdata = {{(32-SW){1'b0}}, used_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= SIZE_RST;
		end else if (psel && penable && pwrite && paddr == 1'(rars_pkg::CFG_USED_SIZE)) begin
			used_q <= pwdata[SW-1:0];
		end
	end

	// clipping of the incoming range
	logic [PW-1:0] n_clip, lo_w, hi_w, hic_w;
	logic          empty_w;
	always_comb begin
		if (used_q == '0) n_clip = PW'(1);
		else if (32'(used_q) > MAX_ELEMENTS) n_clip = NMAX;
		else n_clip = PW'(used_q);
		lo_w = PW'(lo);
		hi_w = PW'(hi);
		hic_w = (hi_w >= n_clip) ? n_clip - PW'(1) : hi_w;
		empty_w = (lo_w >= n_clip) || (lo_w > hic_w);
	end

	logic [PW-1:0] lsb_w;
	assign lsb_w = pos_q & (~pos_q + PW'(1));

	logic [DW-1:0] pref_w;
	assign pref_w = prod_q - s2_q;

	logic [PW-1:0] uidx_w;
	logic signed [32+PW:0] pm_w;
	assign uidx_w = uphase_q ? hic_q + PW'(1) : lo_q;
	assign pm_w = v_q * $signed({1'b0, uidx_w});

	logic [DW-1:0] v48;
	assign v48 = DW'(v_q);

	// next state and memory control
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		wa = clr_q;
		ra = AW'(pos_q - PW'(1));
		wd1 = '0;
		wd2 = '0;
		busy = 1'b1;
		range_valid = 1'b0;
		unique case (state_q)
			rars_pkg::S_CLEAR: begin
				we = 1'b1;
				if (PW'(clr_q) == NMAX - PW'(1)) state_d = rars_pkg::S_IDLE;
			end
			rars_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) state_d = empty_w ? rars_pkg::S_OUT : rars_pkg::S_PRD;
			end
			rars_pkg::S_PRD: state_d = (pos_q == '0) ? rars_pkg::S_PMUL : rars_pkg::S_PAC;
			rars_pkg::S_PAC: state_d = rars_pkg::S_PRD;
			rars_pkg::S_PMUL: state_d = rars_pkg::S_PSUB;
			rars_pkg::S_PSUB: state_d = second_q ? rars_pkg::S_OUT : rars_pkg::S_PRD;
			rars_pkg::S_OUT: begin
				range_valid = 1'b1;
				state_d = op_q ? rars_pkg::S_UMUL : rars_pkg::S_IDLE;
			end
			rars_pkg::S_UMUL: state_d = rars_pkg::S_URD;
			rars_pkg::S_URD: begin
				if (pos_q > NMAX) state_d = uphase_q ? rars_pkg::S_IDLE : rars_pkg::S_UMUL;
				else state_d = rars_pkg::S_UWR;
			end
			rars_pkg::S_UWR: begin
				we = 1'b1;
				wa = AW'(pos_q - PW'(1));
				wd1 = b1_rd_q + d1_q;
				wd2 = b2_rd_q + d2_q;
				state_d = rars_pkg::S_URD;
			end
			default: state_d = rars_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rars_pkg::S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rars_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rars_pkg::S_IDLE: begin
				op_q <= op && !empty_w;
				lo_q <= lo_w;
				hic_q <= hic_w;
				v_q <= add_value;
				total_q <= '0;
				pos_q <= hic_w + PW'(1);
				idx_q <= hic_w + PW'(1);
				s1_q <= '0;
				s2_q <= '0;
				second_q <= 1'b0;
				uphase_q <= 1'b0;
			end
			rars_pkg::S_PAC: begin
				s1_q <= s1_q + b1_rd_q;
				s2_q <= s2_q + b2_rd_q;
				pos_q <= pos_q - lsb_w;
			end
			rars_pkg::S_PMUL: prod_q <= DW'(s1_q * {{(DW-PW){1'b0}}, idx_q});
			rars_pkg::S_PSUB: begin
				if (!second_q) begin
					total_q <= pref_w;
					second_q <= 1'b1;
					pos_q <= lo_q;
					idx_q <= lo_q;
					s1_q <= '0;
					s2_q <= '0;
				end else begin
					total_q <= total_q - pref_w;
				end
			end
			rars_pkg::S_UMUL: begin
				d1_q <= uphase_q ? -v48 : v48;
				d2_q <= uphase_q ? -DW'(pm_w) : DW'(pm_w);
				pos_q <= uidx_w + PW'(1);
			end
			rars_pkg::S_URD: if (pos_q > NMAX) uphase_q <= 1'b1;
			rars_pkg::S_UWR: pos_q <= pos_q + lsb_w;
			default: ;
		endcase
	end

	assign range_sum = total_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rars_checker.sv
// port-level checks for the range add / range sum store
// binds to range_add_range_sum_tree
`default_nettype none
module rars_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic range_valid
);
	// result beat lasts one cycle
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n) range_valid |=> !range_valid)
		else $error("result strobe held");
	// result only while an item is in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) range_valid |-> busy)
		else $error("result while idle");
	// accepted item keeps the block busy
	a_take: assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accept without busy");
endmodule

bind range_add_range_sum_tree rars_checker u_rars_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .range_valid(range_valid)
);
`default_nettype wire

FILE: dv/range_add_range_sum_tree_tb.sv
// testbench for the range add / range sum store: directed and random beats
// checked against a flat-array sum predictor; depends on rars_pkg and the dut
`timescale 1ns / 1ps
module range_add_range_sum_tree_tb;
	localparam int N = rars_pkg::MAX_ELEMENTS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = 1'b0;
	logic [9:0] lo = '0;
	logic [9:0] hi = '0;
	logic signed [31:0] add_value = '0;
	logic range_valid;
	logic signed [47:0] range_sum;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// element values of the store as the predictor sees them
	logic [47:0] elem_val [N];
	int unsigned live_size = N;
	logic [47:0] sum_queue [$];
	int errors = 0;
	int gap_pct = 0;

	range_add_range_sum_tree dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

	// sum over the clipped range, then apply the add for updates
	function automatic logic [47:0] predict_range(input logic o, input int unsigned l,
			input int unsigned h, input logic signed [31:0] v);
		int unsigned n;
		logic [47:0] s;
		logic [47:0] v48;
		n = (live_size < 1) ? 1 : (live_size > N ? N : live_size);
		s = '0;
		v48 = {{16{v[31]}}, v};
		if (h >= n) h = n - 1;
		if (l < n && l <= h) begin
			for (int i = l; i <= h; i++) s += elem_val[i];
			if (o) for (int i = l; i <= h; i++) elem_val[i] += v48;
		end
		return s;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (range_valid) begin
			if (sum_queue.size() == 0) begin
				$display("%0t range_sum expected none actual %h", $time, range_sum);
				errors++;
			end else begin
				if (sum_queue[0] !== range_sum) begin
					$display("%0t range_sum expected %h actual %h",
						$time, sum_queue[0], range_sum);
					errors++;
				end
				void'(sum_queue.pop_front());
			end
		end
	end

	task automatic send_beat(input logic o, input int unsigned l, input int unsigned h,
			input logic signed [31:0] v);
		while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) @(posedge clk);
		start <= 1'b1;
		op <= o;
		lo <= l[9:0];
		hi <= h[9:0];
		add_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sum_queue.push_back(predict_range(o, l, h, v));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sum_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_size(input int unsigned sz);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 1'(rars_pkg::CFG_USED_SIZE);
		pwdata <= sz;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		live_size = sz & 32'h7ff;
	endtask

	task automatic test_directed();
		send_beat(1'b0, 0, 1023, 0);
		send_beat(1'b1, 0, 1023, 32'sh7fffffff);
		send_beat(1'b1, 0, 0, 32'sh80000000);
		send_beat(1'b1, 1023, 1023, -1);
		send_beat(1'b0, 0, 1023, 0);
		send_beat(1'b1, 5, 3, 100);
		send_beat(1'b0, 3, 5, 0);
		send_beat(1'b1, 511, 512, 32'h55555555);
		send_beat(1'b0, 510, 513, 0);
		send_beat(1'b0, 1023, 0, 0);
		write_size(10);
		send_beat(1'b1, 8, 1023, 7);
		send_beat(1'b1, 10, 1023, 9);
		send_beat(1'b0, 0, 1023, 0);
		write_size(0);
		send_beat(1'b1, 0, 1023, 3);
		send_beat(1'b0, 1, 1, 0);
		send_beat(1'b0, 0, 1023, 0);
		write_size(2047);
		send_beat(1'b0, 0, 1023, 0);
		write_size(1024);
		send_beat(1'b0, 0, 1023, 0);
	endtask

	task automatic test_random(input int count);
		int unsigned a, b;
		logic signed [31:0] v;
		for (int k = 0; k < count; k++) begin
			a = $urandom_range(1023, 0);
			b = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
				: a + $urandom_range(40, 0);
			if (b > 1023) b = 1023;
			v = $urandom();
			send_beat($urandom_range(1, 0), a, b, v);
			if (k == count / 2) drain();
		end
	endtask

	initial begin
		for (int i = 0; i < N; i++) elem_val[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		gap_pct = 11;
		test_random(320);
		write_size($urandom_range(1024, 1));
		gap_pct = 83;
		test_random(300);
		write_size(1);
		test_random(20);
		write_size(1024);
		gap_pct = 0;
		test_random(310);
		drain();
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
